@@ rtl/cfr_pkg.sv @@
// ----------------------------------------------------------------------------
// cfr_pkg: shared types and constants of the command frame receiver
//
// Holds the register indexes, the receiver phase codes and the structures
// that pass configuration and result loads between the modules.
// ----------------------------------------------------------------------------
package cfr_pkg;

   // Field widths fixed by the frame format.
   localparam int BYTE_W = 8;
   localparam int LEN_W  = 7;
   localparam int SUM_W  = 16;
   localparam int CSR_W  = 3;

   // Configuration register indexes.
   localparam logic [CSR_W-1:0] CSR_STRICT_CHECKSUM = 3'd0;
   localparam logic [CSR_W-1:0] CSR_HEADER_FIRST    = 3'd1;
   localparam logic [CSR_W-1:0] CSR_HEADER_SECOND   = 3'd2;
   localparam logic [CSR_W-1:0] CSR_TRAILER_FIRST   = 3'd3;
   localparam logic [CSR_W-1:0] CSR_TRAILER_SECOND  = 3'd4;

   // Reset values of the configuration registers.
   localparam logic [BYTE_W-1:0] HEADER_FIRST_RST   = 8'hFE;
   localparam logic [BYTE_W-1:0] HEADER_SECOND_RST  = 8'hEF;
   localparam logic [BYTE_W-1:0] TRAILER_FIRST_RST  = 8'h0D;
   localparam logic [BYTE_W-1:0] TRAILER_SECOND_RST = 8'h0A;

   // Receiver phases, one-hot.
   typedef enum logic [10:0] {
      PH_HDR0  = 11'b000_0000_0001,
      PH_HDR1  = 11'b000_0000_0010,
      PH_CMD   = 11'b000_0000_0100,
      PH_LENH  = 11'b000_0000_1000,
      PH_LENL  = 11'b000_0001_0000,
      PH_DATA  = 11'b000_0010_0000,
      PH_SUMH  = 11'b000_0100_0000,
      PH_SUML  = 11'b000_1000_0000,
      PH_TRL0  = 11'b001_0000_0000,
      PH_TRL1  = 11'b010_0000_0000,
      PH_DRAIN = 11'b100_0000_0000
   } phase_type;

   // Configuration seen by the parser.
   typedef struct packed {
      logic              strict_checksum;
      logic [BYTE_W-1:0] header_first;
      logic [BYTE_W-1:0] header_second;
      logic [BYTE_W-1:0] trailer_first;
      logic [BYTE_W-1:0] trailer_second;
   } cfg_type;

   // Load of the result register; the payload byte comes from the memory.
   typedef struct packed {
      logic             load;
      logic [BYTE_W-1:0] command;
      logic [LEN_W-1:0] length;
      logic             byte_valid;
      logic             last;
      logic [SUM_W-1:0] received_sum;
      logic [SUM_W-1:0] computed_sum;
      logic             sum_match;
   } rsp_load_type;

endpackage

@@ rtl/command_frame_receiver.sv @@
// ----------------------------------------------------------------------------
// command_frame_receiver: serial command frame receiver
//
// Finds header, command, length, payload, checksum and terminator in a byte
// stream, giving one beat per payload byte of an accepted frame, one if empty.
//
//   Channel   Ports                      Direction  Beat
//   req       req_valid/req_ready        in         one received byte
//   rsp       rsp_valid/rsp_ready        out        one payload byte of a frame
//   csr       csr_we/csr_index/csr_wdata in         one register write
//
// Received bytes are accepted back to back outside the read-back of a frame.
// Each read-back read of the payload store waits for the one before to come
// back from its registered port, and input is held off until the last issues.
// Reset clears the phase and the result valid; the store needs no clearing,
// as only entries written in the current frame are read. A stalled rsp beat
// holds the read-back and, on the final terminator byte, the req channel.
// ----------------------------------------------------------------------------
module command_frame_receiver #(
   parameter int MAX_PAYLOAD = 64
) (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       req_valid,
   output logic                       req_ready,
   input  logic [cfr_pkg::BYTE_W-1:0] req_rx_byte,
   output logic                       rsp_valid,
   input  logic                       rsp_ready,
   output logic [cfr_pkg::BYTE_W-1:0] rsp_frame_command,
   output logic [cfr_pkg::LEN_W-1:0]  rsp_frame_length,
   output logic [cfr_pkg::BYTE_W-1:0] rsp_payload_byte,
   output logic                       rsp_byte_valid,
   output logic                       rsp_last,
   output logic [cfr_pkg::SUM_W-1:0]  rsp_received_sum,
   output logic [cfr_pkg::SUM_W-1:0]  rsp_computed_sum,
   output logic                       rsp_sum_match,
   input  logic                       csr_we,
   input  logic [cfr_pkg::CSR_W-1:0]  csr_index,
   input  logic [cfr_pkg::BYTE_W-1:0] csr_wdata
);
   import cfr_pkg::*;

   localparam int ADDR_W = (MAX_PAYLOAD > 1) ? $clog2(MAX_PAYLOAD) : 1;

   cfg_type           cfg_ff;
   rsp_load_type      rsp_load;
   logic              rsp_free;
   logic              ram_we;
   logic [ADDR_W-1:0] ram_waddr;
   logic [BYTE_W-1:0] ram_wdata;
   logic              ram_re;
   logic [ADDR_W-1:0] ram_raddr;
   logic [BYTE_W-1:0] ram_rdata;

   logic              rsp_valid_ff;
   logic [BYTE_W-1:0] command_ff;
   logic [LEN_W-1:0]  length_ff;
   logic [BYTE_W-1:0] payload_ff;
   logic              byte_valid_ff;
   logic              last_ff;
   logic [SUM_W-1:0]  received_sum_ff;
   logic [SUM_W-1:0]  computed_sum_ff;
   logic              sum_match_ff;

   // Configuration registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.strict_checksum <= 1'b0;
         cfg_ff.header_first    <= HEADER_FIRST_RST;
         cfg_ff.header_second   <= HEADER_SECOND_RST;
         cfg_ff.trailer_first   <= TRAILER_FIRST_RST;
         cfg_ff.trailer_second  <= TRAILER_SECOND_RST;
      end else if (csr_we) begin
         case (csr_index)
            CSR_STRICT_CHECKSUM: cfg_ff.strict_checksum <= csr_wdata[0];
            CSR_HEADER_FIRST:    cfg_ff.header_first    <= csr_wdata;
            CSR_HEADER_SECOND:   cfg_ff.header_second   <= csr_wdata;
            CSR_TRAILER_FIRST:   cfg_ff.trailer_first   <= csr_wdata;
            CSR_TRAILER_SECOND:  cfg_ff.trailer_second  <= csr_wdata;
            default: begin
            end
         endcase
      end
   end

   // Frame phase sequencer.
   cfr_frame_parser #(
      .MAX_PAYLOAD (MAX_PAYLOAD),
      .ADDR_W      (ADDR_W)
   ) u_parser (
      .clock       (clock),
      .reset       (reset),
      .cfg         (cfg_ff),
      .req_valid   (req_valid),
      .req_rx_byte (req_rx_byte),
      .req_ready   (req_ready),
      .rsp_free    (rsp_free),
      .ram_we      (ram_we),
      .ram_waddr   (ram_waddr),
      .ram_wdata   (ram_wdata),
      .ram_re      (ram_re),
      .ram_raddr   (ram_raddr),
      .rsp_load    (rsp_load)
   );

   // Payload store.
   cfr_payload_ram #(
      .DEPTH  (MAX_PAYLOAD),
      .ADDR_W (ADDR_W)
   ) u_ram (
      .clock   (clock),
      .wr_en   (ram_we),
      .wr_addr (ram_waddr),
      .wr_data (ram_wdata),
      .rd_en   (ram_re),
      .rd_addr (ram_raddr),
      .rd_data (ram_rdata)
   );

   // The result register is free when empty or when its beat goes this cycle.
   assign rsp_free = !rsp_valid_ff || rsp_ready;

   // Result valid.
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (rsp_load.load) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   // Result payload.
   always_ff @(posedge clock) begin
      if (rsp_load.load) begin
         command_ff      <= rsp_load.command;
         length_ff       <= rsp_load.length;
         payload_ff      <= rsp_load.byte_valid ? ram_rdata : '0;
         byte_valid_ff   <= rsp_load.byte_valid;
         last_ff         <= rsp_load.last;
         received_sum_ff <= rsp_load.received_sum;
         computed_sum_ff <= rsp_load.computed_sum;
         sum_match_ff    <= rsp_load.sum_match;
      end
   end

   assign rsp_valid         = rsp_valid_ff;
   assign rsp_frame_command = command_ff;
   assign rsp_frame_length  = length_ff;
   assign rsp_payload_byte  = payload_ff;
   assign rsp_byte_valid    = byte_valid_ff;
   assign rsp_last          = last_ff;
   assign rsp_received_sum  = received_sum_ff;
   assign rsp_computed_sum  = computed_sum_ff;
   assign rsp_sum_match     = sum_match_ff;

endmodule

@@ rtl/cfr_payload_ram.sv @@
// ----------------------------------------------------------------------------
// cfr_payload_ram: payload byte store
//
// Single write port and one registered read port; read data appears in the
// cycle after the read enable.
// ----------------------------------------------------------------------------
module cfr_payload_ram #(
   parameter int DEPTH,
   parameter int ADDR_W
) (
   input  logic                       clock,
   input  logic                       wr_en,
   input  logic [ADDR_W-1:0]          wr_addr,
   input  logic [cfr_pkg::BYTE_W-1:0] wr_data,
   input  logic                       rd_en,
   input  logic [ADDR_W-1:0]          rd_addr,
   output logic [cfr_pkg::BYTE_W-1:0] rd_data
);
   import cfr_pkg::*;

   logic [BYTE_W-1:0] mem_ff [DEPTH];
   logic [BYTE_W-1:0] rd_data_ff;

   // Write port.
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
   end

   // Registered read port.
   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

@@ rtl/cfr_frame_parser.sv @@
// ----------------------------------------------------------------------------
// cfr_frame_parser: frame phase sequencer and payload drain
//
// Walks the received bytes through the frame phases, writes payload bytes
// into the store and, for an accepted frame, reads them back one per result.
// ----------------------------------------------------------------------------
module cfr_frame_parser #(
   parameter int MAX_PAYLOAD,
   parameter int ADDR_W
) (
   input  logic                         clock,
   input  logic                         reset,
   input  cfr_pkg::cfg_type             cfg,
   input  logic                         req_valid,
   input  logic [cfr_pkg::BYTE_W-1:0]   req_rx_byte,
   output logic                         req_ready,
   input  logic                         rsp_free,
   output logic                         ram_we,
   output logic [ADDR_W-1:0]            ram_waddr,
   output logic [cfr_pkg::BYTE_W-1:0]   ram_wdata,
   output logic                         ram_re,
   output logic [ADDR_W-1:0]            ram_raddr,
   output cfr_pkg::rsp_load_type        rsp_load
);
   import cfr_pkg::*;

   localparam logic [BYTE_W-1:0] MAX_LEN = BYTE_W'(MAX_PAYLOAD);

   phase_type         phase_ff, phase_in;
   logic [BYTE_W-1:0] command_ff, command_in;
   logic              len_hi_nz_ff, len_hi_nz_in;
   logic [LEN_W-1:0]  length_ff, length_in;
   logic [LEN_W-1:0]  byte_idx_ff, byte_idx_in;
   logic [SUM_W-1:0]  rx_sum_ff, rx_sum_in;
   logic [SUM_W-1:0]  run_sum_ff, run_sum_in;
   logic [LEN_W-1:0]  drain_idx_ff, drain_idx_in;
   logic              rd_pend_ff, rd_pend_in;
   logic              rd_last_ff, rd_last_in;
   logic              accept;
   logic              sum_match;
   logic [LEN_W-1:0]  byte_idx_inc;
   logic [LEN_W-1:0]  drain_idx_inc;

   assign accept        = req_valid && req_ready;
   assign sum_match     = (rx_sum_ff == run_sum_ff);
   assign byte_idx_inc  = byte_idx_ff + LEN_W'(1);
   assign drain_idx_inc = drain_idx_ff + LEN_W'(1);

   // Input is held off while the payload is read back, and on the last
   // terminator byte until the result register is free.
   assign req_ready = (phase_ff != PH_DRAIN) && !((phase_ff == PH_TRL1) && !rsp_free);

   // Next-state logic of the frame phases.
   always_comb begin
      phase_in     = phase_ff;
      command_in   = command_ff;
      len_hi_nz_in = len_hi_nz_ff;
      length_in    = length_ff;
      byte_idx_in  = byte_idx_ff;
      rx_sum_in    = rx_sum_ff;
      run_sum_in   = run_sum_ff;
      drain_idx_in = drain_idx_ff;
      rd_pend_in   = 1'b0;
      rd_last_in   = rd_last_ff;
      ram_we       = 1'b0;
      ram_waddr    = byte_idx_ff[ADDR_W-1:0];
      ram_wdata    = req_rx_byte;
      ram_re       = 1'b0;
      ram_raddr    = drain_idx_ff[ADDR_W-1:0];

      rsp_load              = '0;
      rsp_load.command      = command_ff;
      rsp_load.length       = length_ff;
      rsp_load.received_sum = rx_sum_ff;
      rsp_load.computed_sum = run_sum_ff;
      rsp_load.sum_match    = sum_match;

      // A read issued last cycle returns its byte now.
      if (rd_pend_ff) begin
         rsp_load.load       = 1'b1;
         rsp_load.byte_valid = 1'b1;
         rsp_load.last       = rd_last_ff;
      end

      case (phase_ff)
         PH_HDR0: begin
            if (accept && (req_rx_byte == cfg.header_first)) begin
               phase_in = PH_HDR1;
            end
         end
         PH_HDR1: begin
            if (accept) begin
               if (req_rx_byte == cfg.header_second) begin
                  phase_in = PH_CMD;
               end else if (req_rx_byte != cfg.header_first) begin
                  phase_in = PH_HDR0;
               end
            end
         end
         PH_CMD: begin
            if (accept) begin
               command_in = req_rx_byte;
               phase_in   = PH_LENH;
            end
         end
         PH_LENH: begin
            if (accept) begin
               len_hi_nz_in = (req_rx_byte != '0);
               phase_in     = PH_LENL;
            end
         end
         PH_LENL: begin
            if (accept) begin
               length_in   = req_rx_byte[LEN_W-1:0];
               byte_idx_in = '0;
               run_sum_in  = '0;
               if (len_hi_nz_ff || (req_rx_byte > MAX_LEN)) begin
                  phase_in = PH_HDR0;
               end else if (req_rx_byte == '0) begin
                  phase_in = PH_SUMH;
               end else begin
                  phase_in = PH_DATA;
               end
            end
         end
         PH_DATA: begin
            if (accept) begin
               ram_we      = 1'b1;
               run_sum_in  = run_sum_ff + {{(SUM_W-BYTE_W){1'b0}}, req_rx_byte};
               byte_idx_in = byte_idx_inc;
               if (byte_idx_inc >= length_ff) begin
                  phase_in = PH_SUMH;
               end
            end
         end
         PH_SUMH: begin
            if (accept) begin
               rx_sum_in = {req_rx_byte, rx_sum_ff[BYTE_W-1:0]};
               phase_in  = PH_SUML;
            end
         end
         PH_SUML: begin
            if (accept) begin
               rx_sum_in = {rx_sum_ff[SUM_W-1:BYTE_W], req_rx_byte};
               phase_in  = PH_TRL0;
            end
         end
         PH_TRL0: begin
            if (accept) begin
               phase_in = (req_rx_byte == cfg.trailer_first) ? PH_TRL1 : PH_HDR0;
            end
         end
         PH_TRL1: begin
            if (accept) begin
               phase_in = PH_HDR0;
               if ((req_rx_byte == cfg.trailer_second) &&
                   (!cfg.strict_checksum || sum_match)) begin
                  if (length_ff == '0) begin
                     // Empty payload: one result with no byte.
                     rsp_load.load       = 1'b1;
                     rsp_load.byte_valid = 1'b0;
                     rsp_load.last       = 1'b1;
                  end else begin
                     drain_idx_in = '0;
                     phase_in     = PH_DRAIN;
                  end
               end
            end
         end
         PH_DRAIN: begin
            // One read per result, issued once the result register frees up and no read is pending.
            if (rsp_free && !rd_pend_ff) begin
               ram_re       = 1'b1;
               rd_pend_in   = 1'b1;
               rd_last_in   = (drain_idx_inc == length_ff);
               drain_idx_in = drain_idx_inc;
               if (drain_idx_inc == length_ff) begin
                  phase_in = PH_HDR0;
               end
            end
         end
         default: begin
            phase_in = PH_HDR0;
         end
      endcase
   end

   // Control registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff   <= PH_HDR0;
         rd_pend_ff <= 1'b0;
      end else begin
         phase_ff   <= phase_in;
         rd_pend_ff <= rd_pend_in;
      end
   end

   // Frame registers.
   always_ff @(posedge clock) begin
      command_ff   <= command_in;
      len_hi_nz_ff <= len_hi_nz_in;
      length_ff    <= length_in;
      byte_idx_ff  <= byte_idx_in;
      rx_sum_ff    <= rx_sum_in;
      run_sum_ff   <= run_sum_in;
      drain_idx_ff <= drain_idx_in;
      rd_last_ff   <= rd_last_in;
   end

endmodule

@@ verif/tb_top.sv @@
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_top: self-checking testbench of the command frame receiver
//
// Feeds the receiver a stream of serial bytes: a few hand-made frames first,
// then random frames, both well formed and broken, mixed with line noise.
// The scoreboard runs its own frame parser on every accepted byte, queues the
// payload beats each delivered frame must give, and checks every rsp beat
// field by field. Several register settings are used, the extremes among
// them, and at one point the rsp side holds off long enough to stall input.
// ----------------------------------------------------------------------------
module tb_top;
   import cfr_pkg::*;

   localparam int PAYLOAD_MAX      = 64;
   localparam int CYCLE_LIMIT      = 2000000;
   localparam int SETTLE_CYCLES    = 16;
   localparam int LONG_HOLD_CYCLES = 300;
   localparam int PHASE_BYTES      = 110;

   // One rsp beat as the scoreboard expects it.
   typedef struct packed {
      logic [BYTE_W-1:0] command;
      logic [LEN_W-1:0]  length;
      logic [BYTE_W-1:0] payload;
      logic              byte_valid;
      logic              last;
      logic [SUM_W-1:0]  received_sum;
      logic [SUM_W-1:0]  computed_sum;
      logic              sum_match;
   } frame_beat_type;

   // Frame parser of its own plus the queue of beats still owed by the block.
   class frame_scoreboard;
      logic              strict_checksum;
      logic [BYTE_W-1:0] header_first;
      logic [BYTE_W-1:0] header_second;
      logic [BYTE_W-1:0] trailer_first;
      logic [BYTE_W-1:0] trailer_second;

      phase_type         phase;
      logic [BYTE_W-1:0] command;
      logic [15:0]       frame_len;
      int                fill;
      logic [SUM_W-1:0]  rx_sum;
      logic [SUM_W-1:0]  running_sum;
      logic [BYTE_W-1:0] payload_store [PAYLOAD_MAX];

      frame_beat_type    expected_beats[$];
      int                errors;

      function new();
         strict_checksum = 1'b0;
         header_first    = HEADER_FIRST_RST;
         header_second   = HEADER_SECOND_RST;
         trailer_first   = TRAILER_FIRST_RST;
         trailer_second  = TRAILER_SECOND_RST;
         errors          = 0;
         clear_frame();
      endfunction

      function void clear_frame();
         phase       = PH_HDR0;
         command     = '0;
         frame_len   = '0;
         fill        = 0;
         rx_sum      = '0;
         running_sum = '0;
      endfunction

      function void write_reg(logic [CSR_W-1:0] index, logic [BYTE_W-1:0] value);
         case (index)
            CSR_STRICT_CHECKSUM: strict_checksum = value[0];
            CSR_HEADER_FIRST:    header_first    = value;
            CSR_HEADER_SECOND:   header_second   = value;
            CSR_TRAILER_FIRST:   trailer_first   = value;
            CSR_TRAILER_SECOND:  trailer_second  = value;
            default: ;
         endcase
      endfunction

      // Queue the beats of a completed frame, unless strict checking drops it.
      function void queue_frame();
         frame_beat_type beat;
         logic           match;
         int             beats;
         match = (rx_sum == running_sum);
         if (strict_checksum && !match) return;
         beats = (frame_len == 0) ? 1 : int'(frame_len);
         for (int k = 0; k < beats; k++) begin
            beat.command      = command;
            beat.length       = frame_len[LEN_W-1:0];
            beat.payload      = (frame_len == 0) ? '0 : payload_store[k];
            beat.byte_valid   = (frame_len != 0);
            beat.last         = (k == beats - 1);
            beat.received_sum = rx_sum;
            beat.computed_sum = running_sum;
            beat.sum_match    = match;
            expected_beats.push_back(beat);
         end
      endfunction

      // Advance the parser by one accepted req beat.
      function void note_rx_byte(logic [BYTE_W-1:0] b);
         case (phase)
            PH_HDR0: begin
               if (b == header_first) phase = PH_HDR1;
            end
            PH_HDR1: begin
               // A repeated first header byte keeps the hunt where it is.
               if (b == header_second) phase = PH_CMD;
               else if (b != header_first) phase = PH_HDR0;
            end
            PH_CMD: begin
               command = b;
               phase   = PH_LENH;
            end
            PH_LENH: begin
               frame_len = {b, 8'h00};
               phase     = PH_LENL;
            end
            PH_LENL: begin
               frame_len[7:0] = b;
               fill           = 0;
               running_sum    = '0;
               if (frame_len > PAYLOAD_MAX) clear_frame();
               else if (frame_len == 0) phase = PH_SUMH;
               else phase = PH_DATA;
            end
            PH_DATA: begin
               if (fill < PAYLOAD_MAX) begin
                  payload_store[fill] = b;
                  running_sum         = running_sum + b;
                  fill++;
               end
               if (fill >= frame_len || fill >= PAYLOAD_MAX) phase = PH_SUMH;
            end
            PH_SUMH: begin
               rx_sum = {b, 8'h00};
               phase  = PH_SUML;
            end
            PH_SUML: begin
               rx_sum[7:0] = b;
               phase       = PH_TRL0;
            end
            PH_TRL0: begin
               if (b == trailer_first) phase = PH_TRL1;
               else clear_frame();
            end
            PH_TRL1: begin
               if (b == trailer_second) queue_frame();
               clear_frame();
            end
            default: begin
               clear_frame();
            end
         endcase
      endfunction

      function void check_field(string name, logic [15:0] exp_v, logic [15:0] act_v);
         if (exp_v !== act_v) begin
            $error("%s: expected %0h, got %0h", name, exp_v, act_v);
            errors++;
         end
      endfunction

      // Compare one accepted rsp beat with the oldest expectation.
      function void check_beat(frame_beat_type act);
         frame_beat_type exp_b;
         if (expected_beats.size() == 0) begin
            $error("rsp beat with nothing expected: command %0h, payload %0h",
                   act.command, act.payload);
            errors++;
            return;
         end
         exp_b = expected_beats.pop_front();
         check_field("frame_command", exp_b.command, act.command);
         check_field("frame_length", exp_b.length, act.length);
         check_field("payload_byte", exp_b.payload, act.payload);
         check_field("byte_valid", exp_b.byte_valid, act.byte_valid);
         check_field("last", exp_b.last, act.last);
         check_field("received_sum", exp_b.received_sum, act.received_sum);
         check_field("computed_sum", exp_b.computed_sum, act.computed_sum);
         check_field("sum_match", exp_b.sum_match, act.sum_match);
      endfunction

      function int pending();
         return expected_beats.size();
      endfunction
   endclass

   logic              clock = 1'b0;
   logic              reset;
   logic              req_valid;
   logic              req_ready;
   logic [BYTE_W-1:0] req_rx_byte;
   logic              rsp_valid;
   logic              rsp_ready;
   logic [BYTE_W-1:0] rsp_frame_command;
   logic [LEN_W-1:0]  rsp_frame_length;
   logic [BYTE_W-1:0] rsp_payload_byte;
   logic              rsp_byte_valid;
   logic              rsp_last;
   logic [SUM_W-1:0]  rsp_received_sum;
   logic [SUM_W-1:0]  rsp_computed_sum;
   logic              rsp_sum_match;
   logic              csr_we;
   logic [CSR_W-1:0]  csr_index;
   logic [BYTE_W-1:0] csr_wdata;

   frame_scoreboard   sb = new();
   int                bytes_sent  = 0;
   int                cycle_count = 0;
   bit                req_idle_on   = 1'b1;
   bit                rsp_idle_on   = 1'b1;
   bit                long_hold_req = 1'b0;

   command_frame_receiver #(
      .MAX_PAYLOAD(PAYLOAD_MAX)
   ) uut (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_ready        (req_ready),
      .req_rx_byte      (req_rx_byte),
      .rsp_valid        (rsp_valid),
      .rsp_ready        (rsp_ready),
      .rsp_frame_command(rsp_frame_command),
      .rsp_frame_length (rsp_frame_length),
      .rsp_payload_byte (rsp_payload_byte),
      .rsp_byte_valid   (rsp_byte_valid),
      .rsp_last         (rsp_last),
      .rsp_received_sum (rsp_received_sum),
      .rsp_computed_sum (rsp_computed_sum),
      .rsp_sum_match    (rsp_sum_match),
      .csr_we           (csr_we),
      .csr_index        (csr_index),
      .csr_wdata        (csr_wdata)
   );

   // Free-running clock, 2 ns period.
   always begin
      #1 clock = 1'b1;
      #1 clock = 1'b0;
   end

   // Run limit, well beyond the slowest correct run.
   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("DONE: errors detected");
         $finish;
      end
   end

   // Check every rsp beat taken at a rising edge.
   always @(posedge clock) begin
      if (!reset && rsp_valid && rsp_ready) begin
         sb.check_beat('{rsp_frame_command, rsp_frame_length, rsp_payload_byte,
                         rsp_byte_valid, rsp_last, rsp_received_sum,
                         rsp_computed_sum, rsp_sum_match});
      end
   end

   // Receiving side: random stall bursts, and one long hold-off on request.
   initial begin
      rsp_ready = 1'b0;
      forever begin
         @(negedge clock);
         if (long_hold_req) begin
            long_hold_req = 1'b0;
            rsp_ready <= 1'b0;
            repeat (LONG_HOLD_CYCLES) @(negedge clock);
         end else if (rsp_idle_on && $urandom_range(0, 3) == 0) begin
            rsp_ready <= 1'b0;
            repeat ($urandom_range(1, 12) - 1) @(negedge clock);
         end else begin
            rsp_ready <= 1'b1;
         end
      end
   end

   // Offer one byte, after an optional idle burst, and wait for its beat.
   task automatic send_byte(input logic [BYTE_W-1:0] b);
      if (req_idle_on && $urandom_range(0, 5) == 0) begin
         req_valid <= 1'b0;
         repeat ($urandom_range(1, 12)) @(negedge clock);
      end
      req_valid   <= 1'b1;
      req_rx_byte <= b;
      do @(posedge clock); while (!req_ready);
      sb.note_rx_byte(b);
      bytes_sent++;
      @(negedge clock);
   endtask

   // Register write; starts and ends just after a falling edge.
   task automatic write_csr(input logic [CSR_W-1:0] index, input logic [BYTE_W-1:0] value);
      csr_we    <= 1'b1;
      csr_index <= index;
      csr_wdata <= value;
      @(negedge clock);
      sb.write_reg(index, value);
      csr_we <= 1'b0;
      @(negedge clock);
   endtask

   task automatic program_regs(input logic strict, input logic [BYTE_W-1:0] hdr1,
                               input logic [BYTE_W-1:0] hdr2,
                               input logic [BYTE_W-1:0] trl1,
                               input logic [BYTE_W-1:0] trl2);
      write_csr(CSR_STRICT_CHECKSUM, {7'b0, strict});
      write_csr(CSR_HEADER_FIRST, hdr1);
      write_csr(CSR_HEADER_SECOND, hdr2);
      write_csr(CSR_TRAILER_FIRST, trl1);
      write_csr(CSR_TRAILER_SECOND, trl2);
   endtask

   // Wait until every expected beat is in, then let the block settle.
   task automatic wait_idle();
      while (sb.pending() != 0) @(negedge clock);
      repeat (SETTLE_CYCLES) @(negedge clock);
   endtask

   // One random frame: mostly well formed, some broken, some plain noise.
   task automatic send_frame(input int fixed_len);
      logic [BYTE_W-1:0] stream[$];
      logic [15:0]       len16;
      logic [SUM_W-1:0]  sum;
      logic [BYTE_W-1:0] b;
      int                kind;
      int                pick;
      kind = $urandom_range(0, 99);
      if (fixed_len >= 0) kind = 99;
      if (kind < 8) begin
         // Line noise, often carrying a stray first header byte.
         repeat ($urandom_range(1, 6))
            stream.push_back(($urandom_range(0, 2) == 0) ? sb.header_first
                                                         : BYTE_W'($urandom));
      end else begin
         stream.push_back(sb.header_first);
         if ($urandom_range(0, 5) == 0) stream.push_back(sb.header_first);
         stream.push_back(sb.header_second);
         stream.push_back(BYTE_W'($urandom));
         if (kind < 14) begin
            // Length beyond the payload store: the frame is abandoned.
            len16 = ($urandom_range(0, 1) == 0) ? 16'(PAYLOAD_MAX + 1)
                                                : 16'($urandom_range(PAYLOAD_MAX + 1, 65535));
            stream.push_back(len16[15:8]);
            stream.push_back(len16[7:0]);
         end else begin
            pick = $urandom_range(0, 19);
            if (fixed_len >= 0) len16 = 16'(fixed_len);
            else if (pick == 0) len16 = 16'(PAYLOAD_MAX);
            else if (pick < 3) len16 = 16'($urandom_range(9, PAYLOAD_MAX - 1));
            else len16 = 16'($urandom_range(0, 8));
            stream.push_back(len16[15:8]);
            stream.push_back(len16[7:0]);
            sum = '0;
            for (int k = 0; k < int'(len16); k++) begin
               b = BYTE_W'($urandom);
               stream.push_back(b);
               sum = sum + b;
            end
            if (kind < 22) sum = SUM_W'($urandom);
            stream.push_back(sum[15:8]);
            stream.push_back(sum[7:0]);
            // A wrong first or second terminator drops the frame.
            if (kind >= 22 && kind < 27)
               stream.push_back(sb.trailer_first ^ BYTE_W'($urandom_range(1, 255)));
            else
               stream.push_back(sb.trailer_first);
            if (kind >= 27 && kind < 32)
               stream.push_back(sb.trailer_second ^ BYTE_W'($urandom_range(1, 255)));
            else
               stream.push_back(sb.trailer_second);
         end
      end
      foreach (stream[i]) send_byte(stream[i]);
   endtask

   task automatic random_phase(input int target);
      int start;
      start = bytes_sent;
      while (bytes_sent - start < target) begin
         req_idle_on = ($urandom_range(0, 3) != 0);
         rsp_idle_on = ($urandom_range(0, 3) != 0);
         send_frame(-1);
      end
   endtask

   // Hand-made opening frames under the reset settings.
   logic [BYTE_W-1:0] opening_bytes [25] = '{
      // Repeated first header byte, then an empty payload.
      8'hFE, 8'hFE, 8'hEF, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h0D, 8'h0A,
      // Length of one past the largest payload.
      8'hFE, 8'hEF, 8'hFF, 8'h00, 8'h41,
      // Single all-ones payload byte with a matching checksum.
      8'hFE, 8'hEF, 8'hA5, 8'h00, 8'h01, 8'hFF, 8'h00, 8'hFF, 8'h0D, 8'h0A
   };

   initial begin
      reset       = 1'b1;
      req_valid   = 1'b0;
      req_rx_byte = '0;
      csr_we      = 1'b0;
      csr_index   = '0;
      csr_wdata   = '0;
      repeat (11) @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      foreach (opening_bytes[i]) send_byte(opening_bytes[i]);
      req_valid <= 1'b0;
      wait_idle();

      // Strict checking with the usual delimiters.
      program_regs(1'b1, HEADER_FIRST_RST, HEADER_SECOND_RST,
                   TRAILER_FIRST_RST, TRAILER_SECOND_RST);
      random_phase(PHASE_BYTES);
      req_valid <= 1'b0;
      wait_idle();

      // Lenient checking with delimiters at the byte extremes.
      program_regs(1'b0, 8'h00, 8'hFF, 8'hFF, 8'h00);
      random_phase(PHASE_BYTES);
      req_valid <= 1'b0;
      wait_idle();

      // The rsp side holds off while whole frames keep arriving back to back.
      program_regs(1'b1, 8'hFF, 8'h00, 8'h00, 8'hFF);
      req_idle_on   = 1'b0;
      long_hold_req = 1'b1;
      repeat (3) send_frame(16);
      random_phase(PHASE_BYTES - 60);
      req_valid <= 1'b0;
      wait_idle();

      // Random settings, and no idling on either side to the end.
      program_regs(1'($urandom), 8'($urandom), 8'($urandom), 8'($urandom), 8'($urandom));
      req_idle_on = 1'b0;
      rsp_idle_on = 1'b0;
      while (bytes_sent < 460) send_frame(-1);
      req_valid <= 1'b0;
      wait_idle();

      if (sb.errors == 0 && sb.pending() == 0) begin
         $display("DONE: 0 errors");
      end else begin
         $display("DONE: errors detected");
      end
      $finish;
   end

endmodule
